// ===== rtl/core/itba_pkg.sv =====
// Shared constants, types and helper functions for the integer to ASCII converter.
// No dependencies; every other file of the block imports this package.
package itba_pkg;

  // Width of the integer being converted; at most 32 bits of the input word are used.
  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;

  localparam int USE_BITS  = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam bit SIGN_ON   = (VALUE_BITS <= IN_VALUE_W);
  localparam int SIGN_POS  = USE_BITS - 1;
  localparam int BIT_CNT_W = $clog2(USE_BITS);

  // Binary grouping: digits come in groups of eight
  localparam int GROUP_SIZE = 8;
  localparam int GRP_IW     = $clog2(GROUP_SIZE);
  localparam int DIG_DEPTH  = ((USE_BITS + GROUP_SIZE - 1) / GROUP_SIZE) * GROUP_SIZE;
  localparam int DIG_IW     = $clog2(DIG_DEPTH);
  localparam int CNT_W      = $clog2(DIG_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2d;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SHIFT,
    S_PAD,
    S_EMIT
  } state_t;

  typedef logic [USE_BITS-1:0] value_t;
  typedef logic [DIGIT_W-1:0]  digit_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Shift amount for power-of-two radices, zero otherwise
  function automatic logic [2:0] radix_log2(input logic [RADIX_W-1:0] r);
    logic [2:0] res;
    unique case (r)
      RADIX_W'(2):  res = 3'd1;
      RADIX_W'(4):  res = 3'd2;
      RADIX_W'(8):  res = 3'd3;
      RADIX_W'(16): res = 3'd4;
      RADIX_W'(32): res = 3'd5;
      default:      res = 3'd0;
    endcase
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
    logic [CHAR_W-1:0] res;
    if (d >= DIGIT_W'(10)) begin
      res = CHAR_W'(d) + CH_ALPHA_OFS;
    end else begin
      res = CHAR_W'(d) + CH_ZERO;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/itba_in_if.sv =====
// Input channel of the converter: valid/ready plus value, radix and mode.
// Depends on itba_pkg for the field widths.
interface itba_in_if import itba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [RADIX_W-1:0]    radix;
  logic                  signed_mode;

  modport source(output valid, output value, output radix, output signed_mode,
                 input ready);
  modport sink(input valid, input value, input radix, input signed_mode,
               output ready);
endinterface

// ===== rtl/core/itba_out_if.sv =====
// Result channel of the converter: valid/ready plus one character and its last flag.
// Depends on itba_pkg for the field widths.
interface itba_out_if import itba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source(output valid, output character, output last, input ready);
  modport sink(input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/itba_div_step.sv =====
// One restoring division step by a small radix: shift in a dividend bit, trial subtract.
// Depends on itba_pkg.
module itba_div_step import itba_pkg::*; (
  input  digit_t             rem_i,
  input  logic               bit_i,
  input  logic [RADIX_W-1:0] base_i,
  output digit_t             rem_o,
  output logic               qbit_o
);

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;

  assign trial  = {rem_i, bit_i};
  assign diff   = trial - (DIGIT_W+1)'(base_i);
  assign qbit_o = (trial >= (DIGIT_W+1)'(base_i));
  // remainder stays below the radix, so the top bit drops
  assign rem_o  = qbit_o ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

endmodule

// ===== rtl/core/integer_to_base_ascii.sv =====
// Integer to ASCII digits in radix 2..36, one character per output word, MSB first.
// Other radices take digits from the shared divide step, one quotient bit per cycle;
// power-of-two radices shift digits out directly. Grouped binary is padded with zeros,
// then the characters are sent as the output accepts them. Not ready from accept until
// the last character is loaded into the output register; the next number is taken the
// cycle after.
// Synchronous active-low reset clears the sequencer and the output valid.
module integer_to_base_ascii import itba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  itba_in_if.sink    in_ch,
  itba_out_if.source out_ch
);

  state_t             state_r, state_nxt;
  value_t             v_r, v_nxt;
  digit_t             rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [RADIX_W-1:0] base_r, base_nxt;
  logic [2:0]         shamt_r, shamt_nxt;
  logic               neg_r, neg_nxt;
  logic               grp_r, grp_nxt;
  logic [CNT_W-1:0]   nd_r, nd_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  logic               space_pend_r, space_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  digit_t             digs_r [DIG_DEPTH];
  logic               dig_we;
  digit_t             dig_wdata;

  // input side decode
  logic               in_fire;
  value_t             in_v;
  logic [RADIX_W-1:0] in_base;
  logic               in_neg;

  // shared step unit
  digit_t             step_rem;
  logic               step_qbit;
  value_t             q_new;

  // shift extraction
  value_t             v_sh;
  digit_t             sh_digit;
  digit_t             sh_mask;

  logic               pad_more;
  logic               out_load;
  logic [CNT_W-1:0]   emit_idx;
  digit_t             emit_digit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_v        = in_ch.value[USE_BITS-1:0];
  assign in_base     = clamp_radix(in_ch.radix);
  assign in_neg      = SIGN_ON && in_ch.signed_mode && (in_base == RADIX_DEC) &&
                       in_v[SIGN_POS];

  itba_div_step u_step (
    .rem_i  (rem_r),
    .bit_i  (v_r[USE_BITS-1]),
    .base_i (base_r),
    .rem_o  (step_rem),
    .qbit_o (step_qbit)
  );

  assign q_new    = {v_r[USE_BITS-2:0], step_qbit};
  assign v_sh     = v_r >> shamt_r;
  assign sh_mask  = digit_t'((DIGIT_W+1)'(1) << shamt_r) - digit_t'(1);
  assign sh_digit = v_r[DIGIT_W-1:0] & sh_mask;
  assign pad_more = grp_r && (nd_r[GRP_IW-1:0] != '0);

  assign out_load   = !out_valid_r || out_ch.ready;
  assign emit_idx   = nd_r - CNT_W'(1);
  assign emit_digit = digs_r[emit_idx[DIG_IW-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (radix_log2(in_base) != 3'd0) ? S_SHIFT : S_DIV;
        end
      end
      S_DIV: begin
        if (bit_cnt_r == '0 && q_new == '0) begin
          state_nxt = S_PAD;
        end
      end
      S_SHIFT: begin
        if (v_sh == '0) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (!pad_more) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load && !sign_pend_r && !space_pend_r && emit_idx == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    v_nxt          = v_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    base_nxt       = base_r;
    shamt_nxt      = shamt_r;
    neg_nxt        = neg_r;
    grp_nxt        = grp_r;
    nd_nxt         = nd_r;
    sign_pend_nxt  = sign_pend_r;
    space_pend_nxt = space_pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    dig_we         = 1'b0;
    dig_wdata      = step_rem;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          v_nxt          = in_neg ? (~in_v + value_t'(1)) : in_v;
          base_nxt       = in_base;
          shamt_nxt      = radix_log2(in_base);
          neg_nxt        = in_neg;
          grp_nxt        = !in_ch.signed_mode && (in_base == RADIX_MIN);
          nd_nxt         = '0;
          rem_nxt        = '0;
          bit_cnt_nxt    = BIT_CNT_W'(USE_BITS - 1);
        end
      end
      S_DIV: begin
        v_nxt = q_new;
        if (bit_cnt_r == '0) begin
          // quotient done: remainder is the next digit
          dig_we      = 1'b1;
          dig_wdata   = step_rem;
          nd_nxt      = nd_r + CNT_W'(1);
          rem_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(USE_BITS - 1);
        end else begin
          rem_nxt     = step_rem;
          bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        end
      end
      S_SHIFT: begin
        dig_we    = 1'b1;
        dig_wdata = sh_digit;
        v_nxt     = v_sh;
        nd_nxt    = nd_r + CNT_W'(1);
      end
      S_PAD: begin
        if (pad_more) begin
          dig_we    = 1'b1;
          dig_wdata = '0;
          nd_nxt    = nd_r + CNT_W'(1);
        end else begin
          sign_pend_nxt  = neg_r;
          space_pend_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          priority if (sign_pend_r) begin
            out_char_nxt  = CH_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else if (space_pend_r) begin
            out_char_nxt   = CH_SPACE;
            out_last_nxt   = 1'b0;
            space_pend_nxt = 1'b0;
          end else begin
            out_char_nxt   = digit_char(emit_digit);
            out_last_nxt   = (emit_idx == '0);
            nd_nxt         = emit_idx;
            // space after each full group of eight, except at the end
            space_pend_nxt = grp_r && (emit_idx != '0) &&
                             (emit_idx[GRP_IW-1:0] == '0);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      sign_pend_r  <= 1'b0;
      space_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      sign_pend_r  <= sign_pend_nxt;
      space_pend_r <= space_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    base_r     <= base_nxt;
    shamt_r    <= shamt_nxt;
    neg_r      <= neg_nxt;
    grp_r      <= grp_nxt;
    nd_r       <= nd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_we) begin
      digs_r[nd_r[DIG_IW-1:0]] <= dig_wdata;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

endmodule
